// File: rtl/core/mhid_pkg.sv
// ----------------------------------------------------------------------------
// mhid_pkg
// Shared constants for the min-heap insert/delete unit: default sizes,
// command codes, status codes and result field widths.
// ----------------------------------------------------------------------------
package mhid_pkg;

  // Default sizes of the heap store.
  localparam int CAPACITY_DEF    = 1024;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed widths of the result beat fields.
  localparam int STATUS_W    = 2;
  localparam int OUT_MIN_W   = 32;
  localparam int OUT_COUNT_W = 11;

  // Command codes.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

endpackage

// File: rtl/core/min_heap_insert_delete_unit.sv
// ----------------------------------------------------------------------------
// min_heap_insert_delete_unit
// Binary min-heap of signed keys in a memory with one write and one read
// port, with insert and delete-by-value, one result beat per command.
// ----------------------------------------------------------------------------
// One command is worked at a time, and in_stall stays high until its result
// beat has been loaded into the output register. How long an insert takes
// grows with L, the number of levels the new key climbs. A delete scans the
// store one entry per cycle over the N entries held, then sifts the entry that
// fills the hole upward and downward level by level. The single read port of
// the heap memory sets the pace: every entry that is scanned or compared is
// fetched through it one at a time.
// Rejected inserts and deletes of absent keys change nothing.
module min_heap_insert_delete_unit #(
  parameter int CAPACITY    = mhid_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = mhid_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Command channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_command,
  input  logic signed [VALUE_WIDTH-1:0]        in_value,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mhid_pkg::STATUS_W-1:0]        out_status,
  output logic                                 out_heap_empty,
  output logic signed [mhid_pkg::OUT_MIN_W-1:0] out_min_value,
  output logic [mhid_pkg::OUT_COUNT_W-1:0]     out_entry_count
);
  import mhid_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN     = 4'd1;
  localparam logic [3:0] S_DLAST    = 4'd2;
  localparam logic [3:0] S_LIFT_RD  = 4'd3;
  localparam logic [3:0] S_LIFT_CMP = 4'd4;
  localparam logic [3:0] S_SINK_RDL = 4'd5;
  localparam logic [3:0] S_SINK_RDR = 4'd6;
  localparam logic [3:0] S_SINK_CMP = 4'd7;
  localparam logic [3:0] S_PLACE    = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  // Control registers.
  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload registers.
  logic                          cmd_r, cmd_nxt;
  logic signed [VALUE_WIDTH-1:0] key_r, key_nxt;
  logic signed [VALUE_WIDTH-1:0] left_r, left_nxt;
  logic                          has_right_r, has_right_nxt;
  logic [STATUS_W-1:0]           status_r, status_nxt;
  logic signed [VALUE_WIDTH-1:0] root_r;
  logic [STATUS_W-1:0]           out_status_r;
  logic                          out_empty_r;
  logic signed [OUT_MIN_W-1:0]   out_min_r;
  logic [OUT_COUNT_W-1:0]        out_count_r;

  // Heap memory ports.
  logic signed [VALUE_WIDTH-1:0] heap_mem [CAPACITY];
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic signed [VALUE_WIDTH-1:0] wr_data;
  logic [AW-1:0]                 rd_addr;
  logic signed [VALUE_WIDTH-1:0] rd_data_r;

  // Position arithmetic for parent and child lookups.
  logic [CNT_W:0]   left_pos;
  logic [CNT_W:0]   right_pos;
  logic [CNT_W:0]   count_ext;
  logic [CNT_W-1:0] parent_pos;
  logic [CNT_W-1:0] pos_m1;
  logic [CNT_W-1:0] parent_m1;
  logic [CNT_W-1:0] count_m1;
  logic [CNT_W:0]   left_m1;

  // Result field shaping.
  logic [CNT_W+OUT_COUNT_W-1:0]     count_wide;
  logic [VALUE_WIDTH+OUT_MIN_W-1:0] root_wide;
  logic                             load_out;
  logic                             found;
  logic signed [VALUE_WIDTH-1:0]    child_val;
  logic [CNT_W:0]                   child_pos;

  assign left_pos   = {pos_r, 1'b0};
  assign right_pos  = left_pos + (CNT_W+1)'(1);
  assign count_ext  = {1'b0, count_r};
  assign parent_pos = pos_r >> 1;
  assign pos_m1     = pos_r - ONE_C;
  assign parent_m1  = parent_pos - ONE_C;
  assign count_m1   = count_r - ONE_C;
  assign left_m1    = left_pos - (CNT_W+1)'(1);

  assign count_wide = {{OUT_COUNT_W{1'b0}}, count_r};
  assign root_wide  = {{OUT_MIN_W{1'b0}}, root_r};

  assign found = chk_vld_r && (rd_data_r == key_r);

  // Smaller child picks the left one on a tie or when there is no right one.
  always_comb begin
    if (has_right_r && (rd_data_r < left_r)) begin
      child_val = rd_data_r;
      child_pos = right_pos;
    end else begin
      child_val = left_r;
      child_pos = left_pos;
    end
  end

  assign load_out = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // Sequencer and memory port control.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    scan_idx_nxt  = scan_idx_r;
    chk_vld_nxt   = chk_vld_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    left_nxt      = left_r;
    has_right_nxt = has_right_r;
    status_nxt    = status_r;
    wr_en         = 1'b0;
    wr_addr       = pos_m1[AW-1:0];
    wr_data       = key_r;
    rd_addr       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = in_command;
          key_nxt      = in_value;
          status_nxt   = ST_DONE;
          scan_idx_nxt = '0;
          chk_vld_nxt  = 1'b0;
          if (in_command == CMD_INSERT) begin
            if (count_r >= CAP_C) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              count_nxt = count_r + ONE_C;
              pos_nxt   = count_r + ONE_C;
              state_nxt = S_LIFT_RD;
            end
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      // Linear search, one read issued per cycle, compared in the cycle after.
      S_SCAN: begin
        if (found) begin
          pos_nxt     = scan_idx_r;
          rd_addr     = count_m1[AW-1:0];
          chk_vld_nxt = 1'b0;
          state_nxt   = S_DLAST;
        end else if (scan_idx_r < count_r) begin
          rd_addr      = scan_idx_r[AW-1:0];
          scan_idx_nxt = scan_idx_r + ONE_C;
          chk_vld_nxt  = 1'b1;
        end else begin
          chk_vld_nxt = 1'b0;
          if (!chk_vld_r) begin
            status_nxt = ST_NOT_FOUND;
            state_nxt  = S_DONE;
          end
        end
      end

      // Last entry is fetched; it fills the hole unless it is the hole.
      S_DLAST: begin
        count_nxt = count_m1;
        if (pos_r == count_r) begin
          state_nxt = S_DONE;
        end else begin
          key_nxt   = rd_data_r;
          state_nxt = S_LIFT_RD;
        end
      end

      S_LIFT_RD: begin
        if (pos_r > ONE_C) begin
          rd_addr   = parent_m1[AW-1:0];
          state_nxt = S_LIFT_CMP;
        end else if (cmd_r == CMD_INSERT) begin
          state_nxt = S_PLACE;
        end else begin
          state_nxt = S_SINK_RDL;
        end
      end

      // A strictly greater parent moves down into the hole.
      S_LIFT_CMP: begin
        if (rd_data_r > key_r) begin
          wr_en     = 1'b1;
          wr_data   = rd_data_r;
          pos_nxt   = parent_pos;
          state_nxt = S_LIFT_RD;
        end else if (cmd_r == CMD_INSERT) begin
          state_nxt = S_PLACE;
        end else begin
          state_nxt = S_SINK_RDL;
        end
      end

      S_SINK_RDL: begin
        if (left_pos <= count_ext) begin
          rd_addr   = left_m1[AW-1:0];
          state_nxt = S_SINK_RDR;
        end else begin
          state_nxt = S_PLACE;
        end
      end

      S_SINK_RDR: begin
        left_nxt      = rd_data_r;
        has_right_nxt = right_pos <= count_ext;
        rd_addr       = left_pos[AW-1:0];
        state_nxt     = S_SINK_CMP;
      end

      // The smaller child moves up into the hole while it is below the key.
      S_SINK_CMP: begin
        if (key_r <= child_val) begin
          state_nxt = S_PLACE;
        end else begin
          wr_en     = 1'b1;
          wr_data   = child_val;
          pos_nxt   = child_pos[CNT_W-1:0];
          state_nxt = S_SINK_RDL;
        end
      end

      S_PLACE: begin
        wr_en     = 1'b1;
        wr_data   = key_r;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: loads a finished beat, drops once it is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pos_r       <= '0;
      scan_idx_r  <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      scan_idx_r  <= scan_idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, including a copy of the root entry.
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    left_r      <= left_nxt;
    has_right_r <= has_right_nxt;
    status_r    <= status_nxt;
    if (wr_en && (wr_addr == '0)) begin
      root_r <= wr_data;
    end
    if (load_out) begin
      out_status_r <= status_r;
      out_empty_r  <= (count_r == '0);
      out_min_r    <= (count_r == '0) ? '0 : root_wide[OUT_MIN_W-1:0];
      out_count_r  <= count_wide[OUT_COUNT_W-1:0];
    end
  end

  // Heap memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= heap_mem[rd_addr];
  end

  assign in_stall        = !rst_n || (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_heap_empty  = out_empty_r;
  assign out_min_value   = out_min_r;
  assign out_entry_count = out_count_r;

  // The fill count never goes past the capacity.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CAP_C)
    else $error("heap fill count above capacity");

  // An accepted command always starts the sequencer.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted command did not start the sequencer");

  // A rejected insert is only reported with a full heap.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && status_r == ST_FULL) |-> (count_r == CAP_C))
    else $error("insert rejected while heap not full");

  // A delete of an absent key leaves the count alone.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && state_nxt == S_DONE) |=> $stable(count_r))
    else $error("not-found delete changed the fill count");

endmodule
